[sv/hkr_pkg.sv]
package hkr_pkg;

  // Key slots carried by one report on the input channel
  localparam int unsigned IN_FIELDS = 6;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned NOTE_W    = 6;

  localparam logic [CODE_W-1:0] CODE_EMPTY = 8'h00;
  localparam logic [NOTE_W-1:0] NOTE_NONE  = 6'd0;

  // One lane's finding: a qualifying event and its note
  typedef struct packed {
    logic              hit;
    logic [NOTE_W-1:0] note;
  } hkr_evt_t;

  // Fixed QWERTY layout: 19 letters, digits 2, 3, 5, 6, 7 and comma to notes 28..52
  function automatic logic [NOTE_W-1:0] note_of(input logic [CODE_W-1:0] code);
    logic [NOTE_W-1:0] n;
    n = NOTE_NONE;
    case (code)
      8'h05: n = 6'd47;
      8'h06: n = 6'd44;
      8'h07: n = 6'd43;
      8'h08: n = 6'd32;
      8'h0A: n = 6'd46;
      8'h0B: n = 6'd48;
      8'h0D: n = 6'd50;
      8'h10: n = 6'd51;
      8'h11: n = 6'd49;
      8'h14: n = 6'd28;
      8'h15: n = 6'd33;
      8'h16: n = 6'd41;
      8'h17: n = 6'd35;
      8'h18: n = 6'd39;
      8'h19: n = 6'd45;
      8'h1A: n = 6'd30;
      8'h1B: n = 6'd42;
      8'h1C: n = 6'd37;
      8'h1D: n = 6'd40;
      8'h1F: n = 6'd29;
      8'h20: n = 6'd31;
      8'h22: n = 6'd34;
      8'h23: n = 6'd36;
      8'h24: n = 6'd38;
      8'h36: n = 6'd52;
      default: n = NOTE_NONE;
    endcase
    return n;
  endfunction

endpackage

[sv/hkr_lane.sv]
// One slot of one report checked against every slot of the other report
module hkr_lane #(
  parameter int unsigned SLOTS = 6
) (
  input  logic [7:0]             code,
  input  logic [SLOTS-1:0][7:0]  other_keys,
  output hkr_pkg::hkr_evt_t      evt
);
  import hkr_pkg::*;

  logic [SLOTS-1:0]  match;
  logic [NOTE_W-1:0] note;

  // Presence test against the other report
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = (other_keys[i] == code);
    end
  end

  assign note     = note_of(code);
  assign evt.note = note;
  assign evt.hit  = (code != CODE_EMPTY) && !(|match) && (note != NOTE_NONE);

endmodule

[sv/hkr_merge.sv]
// Collects lane findings of one report and sends them out one per cycle unless
// out_ready stalls; releases (low lanes) before presses (high lanes), each in slot order.
module hkr_merge #(
  parameter int unsigned SLOTS = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hkr_pkg::hkr_evt_t [2*SLOTS-1:0]     lane_evt,
  input  logic                                in_valid,
  output logic                                in_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_note_is_on,
  output logic [hkr_pkg::NOTE_W-1:0]          out_note_number,
  output logic                                out_last_event
);
  import hkr_pkg::*;

  localparam int unsigned LANES = 2 * SLOTS;
  localparam int unsigned IDX_W = $clog2(LANES);

  logic [LANES-1:0]              pend_r, pend_nxt;
  logic [LANES-1:0][NOTE_W-1:0]  notes_r;
  logic [LANES-1:0]              new_mask;
  logic [LANES-1:0]              low_bit;
  logic [LANES-1:0]              rest;
  logic [IDX_W-1:0]              pick;
  logic                          emit;
  logic                          last;
  logic                          take;
  logic                          out_valid_r;
  logic                          out_on_r;
  logic [NOTE_W-1:0]             out_note_r;
  logic                          out_last_r;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      new_mask[j] = lane_evt[j].hit;
    end
  end

  // Lowest pending lane goes next
  assign low_bit = pend_r & (~pend_r + {{(LANES-1){1'b0}}, 1'b1});
  assign rest    = pend_r & ~low_bit;
  assign last    = (rest == '0);

  always_comb begin
    pick = '0;
    for (int j = 0; j < LANES; j++) begin
      if (low_bit[j]) begin
        pick = pick | IDX_W'(j);
      end
    end
  end

  assign emit     = (pend_r != '0) && (!out_valid_r || out_ready);
  assign in_ready = (pend_r == '0) || (emit && last);
  assign take     = in_valid && in_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (take) begin
      pend_nxt = new_mask;
    end else if (emit) begin
      pend_nxt = rest;
    end
  end

  // Pending event mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // Notes of the report in flight
  always_ff @(posedge clk) begin
    if (take) begin
      for (int j = 0; j < LANES; j++) begin
        notes_r[j] <= lane_evt[j].note;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_on_r   <= (pick >= IDX_W'(SLOTS));
      out_note_r <= notes_r[pick];
      out_last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_note_is_on  = out_on_r;
  assign out_note_number = out_note_r;
  assign out_last_event  = out_last_r;

endmodule

[sv/hid_key_report_to_note_events_unit.sv]
// Channel | Ports                                   | Role
// in      | in_valid/in_ready, in_key_slot_0..5     | one keyboard report per request
// out     | out_valid/out_ready, out_note_is_on,    | one note event per request,
//         | out_note_number, out_last_event         | last flags end of a report
//
// Each report yields 0..12 events; the single output register drains one
// event per cycle unless out_ready stalls it.
// All lanes compare a report in the cycle it is accepted; the next report is
// accepted in the cycle its predecessor's last event moves to the output.
// Synchronous active-low reset clears the kept report to all empty slots.
// A stalled output holds its event and blocks input until the report's last
// event has moved into the output register.
module hid_key_report_to_note_events_unit #(
  parameter int unsigned REPORT_SLOTS = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_key_slot_0,
  input  logic [7:0]                  in_key_slot_1,
  input  logic [7:0]                  in_key_slot_2,
  input  logic [7:0]                  in_key_slot_3,
  input  logic [7:0]                  in_key_slot_4,
  input  logic [7:0]                  in_key_slot_5,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_note_is_on,
  output logic [hkr_pkg::NOTE_W-1:0]  out_note_number,
  output logic                        out_last_event
);
  import hkr_pkg::*;

  logic [IN_FIELDS-1:0][CODE_W-1:0]     in_keys;
  logic [REPORT_SLOTS-1:0][CODE_W-1:0]  now_keys;
  logic [REPORT_SLOTS-1:0][CODE_W-1:0]  prev_r;
  hkr_evt_t [2*REPORT_SLOTS-1:0]        lane_evt;

  assign in_keys = {in_key_slot_5, in_key_slot_4, in_key_slot_3,
                    in_key_slot_2, in_key_slot_1, in_key_slot_0};

  // Slots beyond the input fields read as empty
  for (genvar i = 0; i < REPORT_SLOTS; i++) begin : g_now
    if (i < IN_FIELDS) begin : g_fld
      assign now_keys[i] = in_keys[i];
    end else begin : g_empty
      assign now_keys[i] = CODE_EMPTY;
    end
  end

  // Release lanes on the kept report, press lanes on the new one
  for (genvar i = 0; i < REPORT_SLOTS; i++) begin : g_lane
    hkr_lane #(.SLOTS(REPORT_SLOTS)) u_off (
      .code       (prev_r[i]),
      .other_keys (now_keys),
      .evt        (lane_evt[i])
    );
    hkr_lane #(.SLOTS(REPORT_SLOTS)) u_on (
      .code       (now_keys[i]),
      .other_keys (prev_r),
      .evt        (lane_evt[REPORT_SLOTS + i])
    );
  end

  hkr_merge #(.SLOTS(REPORT_SLOTS)) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .lane_evt        (lane_evt),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_note_is_on  (out_note_is_on),
    .out_note_number (out_note_number),
    .out_last_event  (out_last_event)
  );

  // Kept report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (in_valid && in_ready) begin
      prev_r <= now_keys;
    end
  end

endmodule

[sv/hkr_chk.sv]
module hkr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_note_is_on,
  input logic [5:0] out_note_number,
  input logic       out_last_event
);

  // Stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_note_number)
      && $stable(out_note_is_on) && $stable(out_last_event))
    else $error("output event changed while stalled");

  // Notes stay inside the key table range
  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_note_number >= 6'd28) && (out_note_number <= 6'd52))
    else $error("note number out of range");

  // Events of a report still queued behind a stalled one block input
  a_no_take_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !out_last_event |-> !in_ready)
    else $error("new report taken before previous one finished");

  // Within a report, no note-off follows a note-on
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_note_is_on && !out_last_event
      |=> !out_valid || out_note_is_on)
    else $error("note-off after note-on within one report");

endmodule

bind hid_key_report_to_note_events_unit hkr_chk u_hkr_chk (.*);
